@@ hw/rtl/sqsl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqsl_pkg: shared types and constants of the ordered store
// depth, word layouts, opcodes, status codes and the cell command bundle
// ----------------------------------------------------------------------------
package sqsl_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_SORTED    = 2'd1,
    OP_POP_FRONT = 2'd2,
    OP_POP_BACK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    status_e                 status;
    logic [OCC_W-1:0]        occupancy;
  } out_word_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    en;
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic held;
    logic fill;
    logic last;
  } cell_pos_t;

endpackage
`default_nettype wire

@@ hw/rtl/sqsl_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqsl_cell: one slot of the ordered store
// holds one value, compares it against the incoming word and shifts left/right
// ----------------------------------------------------------------------------
module sqsl_cell (
  input  wire logic                             clk_i,
  input  wire sqsl_pkg::cell_cmd_t              cmd_i,
  input  wire sqsl_pkg::cell_pos_t              pos_i,
  input  wire logic signed [sqsl_pkg::VAL_W-1:0] left_val_i,
  input  wire logic signed [sqsl_pkg::VAL_W-1:0] right_val_i,
  input  wire logic                             prefix_i,
  output logic                                  prefix_o,
  output logic signed [sqsl_pkg::VAL_W-1:0]     val_o,
  output logic signed [sqsl_pkg::VAL_W-1:0]     tap_o
);

  logic signed [sqsl_pkg::VAL_W-1:0] val_q, val_d;
  logic                              le;

  // entry not greater than the new value
  assign le       = pos_i.held && (val_q <= cmd_i.value);
  assign prefix_o = prefix_i && le;
  assign val_o    = val_q;
  assign tap_o    = pos_i.last ? val_q : '0;

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      sqsl_pkg::OP_APPEND: begin
        if (pos_i.fill) val_d = cmd_i.value;
      end
      sqsl_pkg::OP_SORTED: begin
        if (!prefix_i) begin
          val_d = left_val_i;
        end else if (!le) begin
          val_d = cmd_i.value;
        end
      end
      sqsl_pkg::OP_POP_FRONT: val_d = right_val_i;
      sqsl_pkg::OP_POP_BACK:  val_d = val_q;
      default:                val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) val_q <= val_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/stack_queue_sorted_list_store_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stack_queue_sorted_list_store_unit: bounded ordered store of signed values
// usable as stack, fifo queue or sorted priority queue, built as a cell row
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one word {opcode, value}
//   output channel: out_valid_o / out_stall_i carry one word
//   {removed_value, status, occupancy} for every accepted input word
// result: the result word is written to the output register when the input
//   word is accepted
// throughput: one word per cycle while not stalled; every cell compares and
//   shifts in the same cycle, so the cycle time is set by the ripple of the
//   sorted-insert position flag along the cell row and the back-value or-tree
// reset: the store is empty and the output register holds no word; cell
//   contents are not cleared, only the fill count
// stall: while the output word waits under out_stall_i, the input is stalled;
//   an input word is still taken in the cycle the waiting result leaves
// ----------------------------------------------------------------------------
module stack_queue_sorted_list_store_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sqsl_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sqsl_pkg::out_word_t       out_word_o
);

  localparam int Depth = sqsl_pkg::DEPTH;

  logic [sqsl_pkg::CNT_W-1:0] count_q, count_d;
  logic                       out_valid_q;
  sqsl_pkg::out_word_t        out_q, out_d;

  logic                 in_acc;
  sqsl_pkg::op_e        op;
  sqsl_pkg::status_e    status;
  sqsl_pkg::cell_cmd_t  cmd;
  logic                 full, empty;
  logic signed [sqsl_pkg::VAL_W-1:0] removed;
  logic signed [sqsl_pkg::VAL_W-1:0] back_val;

  logic signed [sqsl_pkg::VAL_W-1:0] cell_val [Depth];
  logic signed [sqsl_pkg::VAL_W-1:0] cell_tap [Depth];
  logic [Depth:0]                    prefix;

  // output register frees up as soon as the waiting word is taken
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign op    = sqsl_pkg::op_e'(in_word_i.opcode);
  assign full  = (count_q == sqsl_pkg::CNT_W'(Depth));
  assign empty = (count_q == '0);

  // back entry: only the last held cell drives its tap
  always_comb begin
    back_val = '0;
    for (int k = 0; k < Depth; k++) begin
      back_val = back_val | cell_tap[k];
    end
  end

  always_comb begin
    status  = sqsl_pkg::ST_OK;
    removed = '0;
    count_d = count_q;
    unique case (op)
      sqsl_pkg::OP_APPEND, sqsl_pkg::OP_SORTED: begin
        if (full) begin
          status = sqsl_pkg::ST_FULL;
        end else begin
          count_d = count_q + sqsl_pkg::CNT_W'(1);
        end
      end
      sqsl_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = sqsl_pkg::ST_EMPTY;
        end else begin
          removed = cell_val[0];
          count_d = count_q - sqsl_pkg::CNT_W'(1);
        end
      end
      sqsl_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = sqsl_pkg::ST_EMPTY;
        end else begin
          removed = back_val;
          count_d = count_q - sqsl_pkg::CNT_W'(1);
        end
      end
      default: status = sqsl_pkg::ST_OK;
    endcase
  end

  // cells only move on an accepted word that actually changes the store
  assign cmd.en    = in_acc && (status == sqsl_pkg::ST_OK);
  assign cmd.op    = op;
  assign cmd.value = in_word_i.value;

  assign out_d.removed_value = removed;
  assign out_d.status        = status;
  assign out_d.occupancy     = sqsl_pkg::OCC_W'(count_d);

  // the front cell sees an always-true position flag
  assign prefix[0] = 1'b1;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    sqsl_pkg::cell_pos_t               pos;
    logic signed [sqsl_pkg::VAL_W-1:0] left_val, right_val;

    assign pos.held = (sqsl_pkg::CNT_W'(i) < count_q);
    assign pos.fill = (sqsl_pkg::CNT_W'(i) == count_q);
    assign pos.last = (sqsl_pkg::CNT_W'(i + 1) == count_q);

    if (i == 0) begin : g_front
      assign left_val = in_word_i.value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == Depth - 1) begin : g_back
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    sqsl_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (pos),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .prefix_i    (prefix[i]),
      .prefix_o    (prefix[i+1]),
      .val_o       (cell_val[i]),
      .tap_o       (cell_tap[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sqsl_pkg::CNT_W'(Depth))
    else $error("fill count beyond depth");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && (op == sqsl_pkg::OP_APPEND || op == sqsl_pkg::OP_SORTED))
    |=> (out_q.status == sqsl_pkg::ST_FULL) && $stable(count_q))
    else $error("insert into full store not dropped");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && empty && (op == sqsl_pkg::OP_POP_FRONT || op == sqsl_pkg::OP_POP_BACK))
    |=> (out_q.status == sqsl_pkg::ST_EMPTY) && (out_q.removed_value == '0))
    else $error("removal from empty store misreported");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q &&
      (out_q.occupancy == sqsl_pkg::OCC_W'(count_q)))
    else $error("result word missing or occupancy mismatch");
`endif

endmodule
`default_nettype wire
